// ----- hdl/espid_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// espid_pkg: shared types and constants for the encoder speed PID block
// Register indexes, field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package espid_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_GAIN_P         = 3'd0;
  localparam logic [2:0] REG_GAIN_I         = 3'd1;
  localparam logic [2:0] REG_GAIN_D         = 3'd2;
  localparam logic [2:0] REG_SCALE_TENTHS   = 3'd3;
  localparam logic [2:0] REG_OFFTRACK_LEVEL = 3'd4;
  localparam logic [2:0] REG_DRIVE_LIMIT    = 3'd5;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 14;

  // |count * 10| fits 19 bits
  localparam int QUOT_W = 19;
  localparam int DIVC_W = 5;
  localparam logic [DIVC_W-1:0] DIV_LAST = DIVC_W'(QUOT_W - 1);

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 96;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ERR,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_SUM,
    ST_DONE
  } state_t;

  // multiplier operand select
  typedef enum logic [1:0] {
    MSEL_P,
    MSEL_I,
    MSEL_D
  } msel_t;

  typedef struct packed {
    logic  in_ready;
    logic  div_step;
    logic  err_load;
    logic  mul_en;
    msel_t mul_sel;
    logic  acc_add;
    logic  finish;
  } ctrl_t;

endpackage

// ----- hdl/encoder_speed_incremental_pid.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_speed_incremental_pid: incremental PID speed loop for one motor
// One input word per control tick: encoder count, two line-sensor levels and
// a target speed. One output word per tick: forward / reverse duty, the
// clamped drive, the corrected speed and the running distance.
// Usage:
//   - in_* channel takes a word when in_tvalid && in_tready. in_tready is high
//     only while the sequencer is idle; one word is processed at a time.
//   - From accept to out_tvalid the word passes a one-bit-per-cycle
//     restoring divider for count*10/scale_tenths, an error-term step, the
//     P, I and D products through one shared 22x11 multiplier, an add step
//     and a clamp/output step. The sequencer then returns to idle and only
//     there takes the next word, so a new word is not taken before the last
//     result is registered.
//   - out_* holds the result in a register; the next word is accepted and
//     worked on while it waits. If the receiver still stalls when the next
//     result is done, the sequencer holds in its last step until it drains.
//   - cfg_* writes a register whenever cfg_wr_en is high; write only while
//     idle. Unknown indexes are ignored.
//   - Reset (rst_n low, synchronous) restores register defaults, clears the
//     drive, error history and distance, and drops out_tvalid.
// ----------------------------------------------------------------------------
module encoder_speed_incremental_pid #(
  parameter int PWM_PERIOD = 12500
) (
  input  logic clk,
  input  logic rst_n,

  // fields from bit 0: encoder_count[15:0], left_level[27:16],
  // right_level[39:28], target_speed[47:40]
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [espid_pkg::IN_DATA_W-1:0]     in_tdata,

  // fields from bit 0: forward_duty[13:0], reverse_duty[27:14],
  // drive_value[42:28], measured_speed[62:43], distance_total[94:63], pad
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [espid_pkg::OUT_DATA_W-1:0]    out_tdata,

  input  logic                                cfg_wr_en,
  input  logic [espid_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [espid_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [9:0]  gain_p_r, gain_i_r, gain_d_r, scale_tenths_r;
  logic [11:0] offtrack_level_r;
  logic [13:0] drive_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r         <= 10'd80;
      gain_i_r         <= 10'd50;
      gain_d_r         <= 10'd0;
      scale_tenths_r   <= 10'd106;
      offtrack_level_r <= 12'd10;
      drive_limit_r    <= 14'd2500;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        espid_pkg::REG_GAIN_P:         gain_p_r         <= cfg_wdata[9:0];
        espid_pkg::REG_GAIN_I:         gain_i_r         <= cfg_wdata[9:0];
        espid_pkg::REG_GAIN_D:         gain_d_r         <= cfg_wdata[9:0];
        espid_pkg::REG_SCALE_TENTHS:   scale_tenths_r   <= cfg_wdata[9:0];
        espid_pkg::REG_OFFTRACK_LEVEL: offtrack_level_r <= cfg_wdata[11:0];
        espid_pkg::REG_DRIVE_LIMIT:    drive_limit_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // input field split
  // --------------------------------------------------------------------------
  logic signed [15:0] in_count;
  logic        [11:0] in_left, in_right;
  logic signed [7:0]  in_target;

  assign in_count  = $signed(in_tdata[15:0]);
  assign in_left   = in_tdata[27:16];
  assign in_right  = in_tdata[39:28];
  assign in_target = $signed(in_tdata[47:40]);

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  espid_pkg::state_t state_r, state_nxt;
  espid_pkg::ctrl_t  ctrl;
  logic [espid_pkg::DIVC_W-1:0] div_cnt_r;
  logic out_tvalid_r;
  logic out_free;

  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      espid_pkg::ST_IDLE:  if (in_tvalid) state_nxt = espid_pkg::ST_DIV;
      espid_pkg::ST_DIV:   if (div_cnt_r == espid_pkg::DIV_LAST) state_nxt = espid_pkg::ST_ERR;
      espid_pkg::ST_ERR:   state_nxt = espid_pkg::ST_MUL_P;
      espid_pkg::ST_MUL_P: state_nxt = espid_pkg::ST_MUL_I;
      espid_pkg::ST_MUL_I: state_nxt = espid_pkg::ST_MUL_D;
      espid_pkg::ST_MUL_D: state_nxt = espid_pkg::ST_SUM;
      espid_pkg::ST_SUM:   state_nxt = espid_pkg::ST_DONE;
      espid_pkg::ST_DONE:  if (out_free) state_nxt = espid_pkg::ST_IDLE;
      default:             state_nxt = espid_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    ctrl.mul_sel = espid_pkg::MSEL_P;
    case (state_r)
      espid_pkg::ST_IDLE:  ctrl.in_ready = 1'b1;
      espid_pkg::ST_DIV:   ctrl.div_step = 1'b1;
      espid_pkg::ST_ERR:   ctrl.err_load = 1'b1;
      espid_pkg::ST_MUL_P: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = espid_pkg::MSEL_P;
      end
      espid_pkg::ST_MUL_I: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = espid_pkg::MSEL_I;
        ctrl.acc_add = 1'b1;
      end
      espid_pkg::ST_MUL_D: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = espid_pkg::MSEL_D;
        ctrl.acc_add = 1'b1;
      end
      espid_pkg::ST_SUM:   ctrl.acc_add = 1'b1;
      espid_pkg::ST_DONE:  ctrl.finish = out_free;
      default: ;
    endcase
  end

  assign in_tready = ctrl.in_ready;

  logic in_fire;
  assign in_fire = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= espid_pkg::ST_IDLE;
      div_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_fire)            div_cnt_r <= '0;
      else if (ctrl.div_step) div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // loop state: distance, drive, error history
  // --------------------------------------------------------------------------
  logic signed [31:0] distance_acc_r;
  logic signed [14:0] drive_acc_r;
  logic signed [19:0] prev_error_r, prev_prev_error_r;
  logic signed [7:0]  target_r;
  logic               offtrack;

  assign offtrack = (in_left < offtrack_level_r) && (in_right < offtrack_level_r);

  // --------------------------------------------------------------------------
  // restoring divider: |count*10| / scale, one quotient bit per cycle
  // --------------------------------------------------------------------------
  logic signed [19:0]           count_x10;
  logic [espid_pkg::QUOT_W-1:0] count_mag;
  logic [espid_pkg::QUOT_W-1:0] div_q_r;
  logic [9:0]                   div_rem_r, divisor_r;
  logic                         neg_r;
  logic [10:0]                  rem_sh, rem_diff;
  logic                         rem_ge;

  assign count_x10 = (20'(in_count) <<< 3) + (20'(in_count) <<< 1);
  assign count_mag = count_x10[19] ? espid_pkg::QUOT_W'(-count_x10)
                                   : espid_pkg::QUOT_W'(count_x10);

  assign rem_sh   = {div_rem_r, div_q_r[espid_pkg::QUOT_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, divisor_r};
  assign rem_diff = rem_sh - {1'b0, divisor_r};

  // --------------------------------------------------------------------------
  // error terms
  // --------------------------------------------------------------------------
  logic signed [19:0] speed, speed_r;
  logic signed [19:0] err;
  logic signed [20:0] de1;
  logic signed [21:0] d2;
  logic signed [19:0] err_r;
  logic signed [20:0] de1_r;
  logic signed [21:0] d2_r;

  assign speed = neg_r ? -20'($signed({1'b0, div_q_r})) : 20'($signed({1'b0, div_q_r}));
  assign err   = 20'(21'(target_r) - 21'(speed));
  assign de1   = 21'(err) - 21'(prev_error_r);
  assign d2    = 22'(err) - (22'(prev_error_r) <<< 1) + 22'(prev_prev_error_r);

  // --------------------------------------------------------------------------
  // shared multiplier and accumulator
  // --------------------------------------------------------------------------
  logic signed [21:0] mul_a;
  logic        [9:0]  mul_g;
  logic signed [32:0] mul_prod, prod_r;
  logic signed [34:0] acc_r;

  always_comb begin
    case (ctrl.mul_sel)
      espid_pkg::MSEL_P: begin
        mul_a = 22'(de1_r);
        mul_g = gain_p_r;
      end
      espid_pkg::MSEL_I: begin
        mul_a = 22'(err_r);
        mul_g = gain_i_r;
      end
      espid_pkg::MSEL_D: begin
        mul_a = d2_r;
        mul_g = gain_d_r;
      end
      default: begin
        mul_a = '0;
        mul_g = '0;
      end
    endcase
  end

  assign mul_prod = 33'(mul_a) * 33'($signed({1'b0, mul_g}));

  // --------------------------------------------------------------------------
  // clamp to +/- min(drive_limit, PWM_PERIOD)
  // --------------------------------------------------------------------------
  logic [13:0]        lim;
  logic signed [34:0] lim_pos;
  logic signed [14:0] drive;

  assign lim     = ({3'b0, drive_limit_r} > 17'(PWM_PERIOD)) ? 14'(PWM_PERIOD) : drive_limit_r;
  assign lim_pos = $signed({21'b0, lim});

  always_comb begin
    if (acc_r > lim_pos)       drive = $signed({1'b0, lim});
    else if (acc_r < -lim_pos) drive = -$signed({1'b0, lim});
    else                       drive = acc_r[14:0];
  end

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      distance_acc_r    <= '0;
      drive_acc_r       <= '0;
      prev_error_r      <= '0;
      prev_prev_error_r <= '0;
    end else begin
      if (in_fire) begin
        distance_acc_r <= distance_acc_r + 32'(in_count);
        if (offtrack) drive_acc_r <= '0;
      end
      if (ctrl.finish) begin
        drive_acc_r       <= drive;
        prev_prev_error_r <= prev_error_r;
        prev_error_r      <= err_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      target_r  <= offtrack ? 8'sd0 : in_target;
      neg_r     <= count_x10[19];
      div_q_r   <= count_mag;
      div_rem_r <= '0;
      divisor_r <= (scale_tenths_r == 10'd0) ? 10'd1 : scale_tenths_r;
    end else if (ctrl.div_step) begin
      div_rem_r <= rem_ge ? rem_diff[9:0] : rem_sh[9:0];
      div_q_r   <= {div_q_r[espid_pkg::QUOT_W-2:0], rem_ge};
    end
    if (ctrl.err_load) begin
      speed_r <= speed;
      err_r   <= err;
      de1_r   <= de1;
      d2_r    <= d2;
      acc_r   <= 35'(drive_acc_r);
    end else if (ctrl.acc_add) begin
      acc_r <= acc_r + 35'(prod_r);
    end
    if (ctrl.mul_en) prod_r <= mul_prod;
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  logic [espid_pkg::OUT_DATA_W-1:0] out_tdata_r;
  logic [13:0] fwd_duty, rev_duty;
  logic signed [14:0] drive_neg;

  assign drive_neg = -drive;
  assign fwd_duty  = drive[14] ? 14'd0 : drive[13:0];
  assign rev_duty  = drive[14] ? drive_neg[13:0] : 14'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctrl.finish) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      out_tdata_r <= {1'b0, distance_acc_r, speed_r, drive, rev_duty, fwd_duty};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
